/* design/child_world_transform_and_bounds_defines.svh */
// Assertion macros used by the transform block checker.
`ifndef CHILD_WORLD_TRANSFORM_AND_BOUNDS_DEFINES_SVH
`define CHILD_WORLD_TRANSFORM_AND_BOUNDS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWTB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CWTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cwtb_pkg.sv */
// Shared constants and the round/saturate helper for the transform block.
package cwtb_pkg;

    localparam int VEC_LANES    = 3;
    localparam int QUAT_LANES   = 4;
    localparam int POS_INT_BITS = 8;
    localparam int ROT_INT_BITS = 2;
    localparam int OUT_FIELDS   = 7;

    // Round to nearest (ties away from zero), drop s fraction bits, saturate to lb bits.
    function automatic logic signed [63:0] narrow(input logic signed [63:0] v,
                                                  input int unsigned s,
                                                  input int unsigned lb);
        logic [63:0]        mag;
        logic signed [63:0] r;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        mag = v[63] ? -v : v;
        mag = (mag + (64'd1 << (s - 1))) >> s;
        r   = v[63] ? -$signed(mag) : $signed(mag);
        hi  = (64'sd1 <<< (lb - 1)) - 64'sd1;
        lo  = -hi - 64'sd1;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r;
    endfunction

endpackage

/* design/child_world_transform_and_bounds.sv */
// Child world transform and bounds: six-stage fixed-point compose pipeline.
//
// Composes a child's local position, quaternion and scale with its parent's world axes,
// translation and scale, and optionally carries a local box into world space. Positions,
// scales and box lanes are signed Q8.8 style (LANE_BITS-8 fraction bits), axes and the
// quaternion Q2.14 style (LANE_BITS-2 fraction bits); every narrowing rounds to nearest,
// ties away from zero, and saturates. One beat is taken per cycle unless the master side
// stalls. A result is presented on the master side from the last of six register stages:
// the accepting edge loads the first, and the beat moves one stage on whenever the next
// stage can load. Each stage holds one layer of lane multipliers or one layer of three-term
// sums with round/saturate. Stalls on the master side back up stage by stage; nothing is
// dropped or repeated. With has_bounds low the box fields and bounds_valid read zero.
module child_world_transform_and_bounds
    import cwtb_pkg::*;
#(
    parameter int LANE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // local_position, local_rotation(w,x,y,z), local_scale, parent_axis_x, parent_axis_y,
    // parent_axis_z, parent_translation, parent_scale, box_center, box_extents, zero pad
    input  logic [((9*VEC_LANES*LANE_BITS+QUAT_LANES*LANE_BITS+7)/8)*8-1:0] i_s_tdata,
    // has_bounds
    input  logic [0:0] i_s_tuser,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // world_axis_x, world_axis_y, world_axis_z, world_translation, world_scale,
    // world_box_center, world_box_extents, zero pad
    output logic [((OUT_FIELDS*VEC_LANES*LANE_BITS+7)/8)*8-1:0] o_m_tdata,
    // bounds_valid
    output logic [0:0] o_m_tuser
);

    localparam int L        = LANE_BITS;
    localparam int PW       = 2 * L;
    localparam int POS_FRAC = L - POS_INT_BITS;
    localparam int ROT_FRAC = L - ROT_INT_BITS;
    localparam int VEC_W    = VEC_LANES * L;
    localparam int QUAT_W   = QUAT_LANES * L;
    localparam int OFF_POS  = 0;
    localparam int OFF_ROT  = VEC_W;
    localparam int OFF_LSC  = VEC_W + QUAT_W;
    localparam int OFF_PAX  = 2 * VEC_W + QUAT_W;
    localparam int OFF_PT   = 5 * VEC_W + QUAT_W;
    localparam int OFF_PSC  = 6 * VEC_W + QUAT_W;
    localparam int OFF_BC   = 7 * VEC_W + QUAT_W;
    localparam int OFF_BE   = 8 * VEC_W + QUAT_W;
    localparam int NSTG     = 6;

    // quaternion product slots
    localparam int QXX = 0, QYY = 1, QZZ = 2, QXY = 3, QXZ = 4, QYZ = 5, QWX = 6, QWY = 7,
                   QWZ = 8;

    function automatic logic signed [L-1:0] nl(input logic signed [63:0] v, input int s);
        logic signed [63:0] t;
        t = narrow(v, s, L);
        return t[L-1:0];
    endfunction

    // ---------------- input unpack ----------------
    logic signed [L-1:0] s_pos [3];
    logic signed [L-1:0] s_q   [4];
    logic signed [L-1:0] s_lsc [3];
    logic signed [L-1:0] s_pax [3][3];
    logic signed [L-1:0] s_pt  [3];
    logic signed [L-1:0] s_psc [3];
    logic signed [L-1:0] s_bc  [3];
    logic signed [L-1:0] s_be  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_pos[k] = i_s_tdata[OFF_POS + k*L +: L];
            s_lsc[k] = i_s_tdata[OFF_LSC + k*L +: L];
            s_pt[k]  = i_s_tdata[OFF_PT  + k*L +: L];
            s_psc[k] = i_s_tdata[OFF_PSC + k*L +: L];
            s_bc[k]  = i_s_tdata[OFF_BC  + k*L +: L];
            s_be[k]  = i_s_tdata[OFF_BE  + k*L +: L];
            for (int i = 0; i < 3; i++) begin
                s_pax[k][i] = i_s_tdata[OFF_PAX + k*VEC_W + i*L +: L];
            end
        end
        for (int k = 0; k < 4; k++) begin
            s_q[k] = i_s_tdata[OFF_ROT + k*L +: L];
        end
    end

    // ---------------- stage handshake ----------------
    // A stage loads when it is empty or the stage after it is moving.
    logic [NSTG:1] r_v;
    logic [NSTG:1] en;

    always_comb begin
        en[NSTG] = !r_v[NSTG] || i_m_tready;
        for (int s = NSTG - 1; s >= 1; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_s_tvalid;
            for (int s = 2; s <= NSTG; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    assign o_s_tready = en[1];

    // ---------------- stage 1: quaternion, scale and position products ----------------
    logic signed [PW-1:0] r1_qq  [9];
    logic signed [PW-1:0] r1_spp [3];
    logic signed [PW-1:0] r1_wsp [3];
    logic signed [L-1:0]  r1_pax [3][3];
    logic signed [L-1:0]  r1_pt  [3];
    logic signed [L-1:0]  r1_bc  [3];
    logic signed [L-1:0]  r1_be  [3];
    logic                 r1_hb;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_qq[QXX] <= s_q[1] * s_q[1];
            r1_qq[QYY] <= s_q[2] * s_q[2];
            r1_qq[QZZ] <= s_q[3] * s_q[3];
            r1_qq[QXY] <= s_q[1] * s_q[2];
            r1_qq[QXZ] <= s_q[1] * s_q[3];
            r1_qq[QYZ] <= s_q[2] * s_q[3];
            r1_qq[QWX] <= s_q[0] * s_q[1];
            r1_qq[QWY] <= s_q[0] * s_q[2];
            r1_qq[QWZ] <= s_q[0] * s_q[3];
            for (int k = 0; k < 3; k++) begin
                r1_spp[k] <= s_pos[k] * s_psc[k];
                r1_wsp[k] <= s_psc[k] * s_lsc[k];
                r1_pt[k]  <= s_pt[k];
                r1_bc[k]  <= s_bc[k];
                r1_be[k]  <= s_be[k];
                for (int i = 0; i < 3; i++) r1_pax[k][i] <= s_pax[k][i];
            end
            r1_hb <= i_s_tuser[0];
        end
    end

    // ---------------- stage 2: rotation matrix, scaled position, world scale ----------------
    logic signed [L-1:0] n2_rot [3][3];
    logic signed [L-1:0] n2_sp  [3];
    logic signed [L-1:0] n2_ws  [3];

    always_comb begin
        logic signed [63:0] one, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        one = 64'sd1 <<< (2 * ROT_FRAC);
        xx = 64'(r1_qq[QXX]); yy = 64'(r1_qq[QYY]); zz = 64'(r1_qq[QZZ]);
        xy = 64'(r1_qq[QXY]); xz = 64'(r1_qq[QXZ]); yz = 64'(r1_qq[QYZ]);
        wx = 64'(r1_qq[QWX]); wy = 64'(r1_qq[QWY]); wz = 64'(r1_qq[QWZ]);
        n2_rot[0][0] = nl(one - 64'sd2 * (yy + zz), ROT_FRAC);
        n2_rot[0][1] = nl(64'sd2 * (xy + wz), ROT_FRAC);
        n2_rot[0][2] = nl(64'sd2 * (xz - wy), ROT_FRAC);
        n2_rot[1][0] = nl(64'sd2 * (xy - wz), ROT_FRAC);
        n2_rot[1][1] = nl(one - 64'sd2 * (xx + zz), ROT_FRAC);
        n2_rot[1][2] = nl(64'sd2 * (yz + wx), ROT_FRAC);
        n2_rot[2][0] = nl(64'sd2 * (xz + wy), ROT_FRAC);
        n2_rot[2][1] = nl(64'sd2 * (yz - wx), ROT_FRAC);
        n2_rot[2][2] = nl(one - 64'sd2 * (xx + yy), ROT_FRAC);
        for (int k = 0; k < 3; k++) begin
            n2_sp[k] = nl(64'(r1_spp[k]), POS_FRAC);
            n2_ws[k] = nl(64'(r1_wsp[k]), POS_FRAC);
        end
    end

    logic signed [L-1:0] r2_rot [3][3];
    logic signed [L-1:0] r2_sp  [3];
    logic signed [L-1:0] r2_ws  [3];
    logic signed [L-1:0] r2_pax [3][3];
    logic signed [L-1:0] r2_pt  [3];
    logic signed [L-1:0] r2_bc  [3];
    logic signed [L-1:0] r2_be  [3];
    logic                r2_hb;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int k = 0; k < 3; k++) begin
                r2_sp[k] <= n2_sp[k];
                r2_ws[k] <= n2_ws[k];
                r2_pt[k] <= r1_pt[k];
                r2_bc[k] <= r1_bc[k];
                r2_be[k] <= r1_be[k];
                for (int i = 0; i < 3; i++) begin
                    r2_rot[k][i] <= n2_rot[k][i];
                    r2_pax[k][i] <= r1_pax[k][i];
                end
            end
            r2_hb <= r1_hb;
        end
    end

    // ---------------- stage 3: axis, translation and box products ----------------
    logic signed [PW-1:0] r3_axp [3][3][3];  // [column j][lane i][term k]
    logic signed [PW-1:0] r3_tp  [3][3];     // [lane i][term k]
    logic signed [PW-1:0] r3_cp  [3];
    logic signed [PW-1:0] r3_ep  [3];
    logic signed [L-1:0]  r3_pt  [3];
    logic signed [L-1:0]  r3_ws  [3];
    logic                 r3_hb;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r3_tp[i][k] <= r2_pax[k][i] * r2_sp[k];
                    for (int j = 0; j < 3; j++) begin
                        r3_axp[j][i][k] <= r2_pax[k][i] * r2_rot[j][k];
                    end
                end
                r3_cp[i] <= r2_bc[i] * r2_ws[i];
                r3_ep[i] <= r2_be[i] * r2_ws[i];
                r3_pt[i] <= r2_pt[i];
                r3_ws[i] <= r2_ws[i];
            end
            r3_hb <= r2_hb;
        end
    end

    // ---------------- stage 4: world axes, translation, scaled box ----------------
    logic signed [L-1:0] n4_wax [3][3];
    logic signed [L-1:0] n4_wt  [3];
    logic signed [L-1:0] n4_sc  [3];
    logic [L:0]          n4_ex  [3];   // magnitude can reach 2^(L-1)

    always_comb begin
        logic signed [63:0] acc;
        logic signed [63:0] t;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 64'(r3_axp[j][i][0]) + 64'(r3_axp[j][i][1]) + 64'(r3_axp[j][i][2]);
                n4_wax[j][i] = nl(acc, ROT_FRAC);
            end
            acc = (64'(r3_pt[i]) <<< ROT_FRAC) + 64'(r3_tp[i][0]) + 64'(r3_tp[i][1])
                + 64'(r3_tp[i][2]);
            n4_wt[i] = nl(acc, ROT_FRAC);
            n4_sc[i] = nl(64'(r3_cp[i]), POS_FRAC);
            t = 64'(nl(64'(r3_ep[i]), POS_FRAC));
            t = t[63] ? -t : t;
            n4_ex[i] = t[L:0];
        end
    end

    logic signed [L-1:0] r4_wax [3][3];
    logic signed [L-1:0] r4_wt  [3];
    logic signed [L-1:0] r4_sc  [3];
    logic [L:0]          r4_ex  [3];
    logic signed [L-1:0] r4_ws  [3];
    logic                r4_hb;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) r4_wax[j][i] <= n4_wax[j][i];
                r4_wt[i] <= n4_wt[i];
                r4_sc[i] <= n4_sc[i];
                r4_ex[i] <= n4_ex[i];
                r4_ws[i] <= r3_ws[i];
            end
            r4_hb <= r3_hb;
        end
    end

    // ---------------- stage 5: box centre and extent products ----------------
    logic [L-1:0] s4_awax [3][3];

    always_comb begin
        logic signed [63:0] t;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                t = 64'(r4_wax[k][i]);
                t = t[63] ? -t : t;
                s4_awax[k][i] = t[L-1:0];
            end
        end
    end

    logic signed [PW-1:0] r5_cp  [3][3];   // [lane i][term k]
    logic [PW:0]          r5_ep  [3][3];
    logic signed [L-1:0]  r5_wax [3][3];
    logic signed [L-1:0]  r5_wt  [3];
    logic signed [L-1:0]  r5_ws  [3];
    logic                 r5_hb;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r5_cp[i][k]  <= r4_wax[k][i] * r4_sc[k];
                    r5_ep[i][k]  <= s4_awax[k][i] * r4_ex[k];
                    r5_wax[k][i] <= r4_wax[k][i];
                end
                r5_wt[i] <= r4_wt[i];
                r5_ws[i] <= r4_ws[i];
            end
            r5_hb <= r4_hb;
        end
    end

    // ---------------- stage 6: box sums, output register ----------------
    logic signed [L-1:0] n6_wc [3];
    logic signed [L-1:0] n6_we [3];

    always_comb begin
        logic signed [63:0] acc;
        for (int i = 0; i < 3; i++) begin
            acc = (64'(r5_wt[i]) <<< ROT_FRAC) + 64'(r5_cp[i][0]) + 64'(r5_cp[i][1])
                + 64'(r5_cp[i][2]);
            n6_wc[i] = r5_hb ? nl(acc, ROT_FRAC) : '0;
            acc = 64'(r5_ep[i][0]) + 64'(r5_ep[i][1]) + 64'(r5_ep[i][2]);
            n6_we[i] = r5_hb ? nl(acc, ROT_FRAC) : '0;
        end
    end

    logic signed [L-1:0] r6_wax [3][3];
    logic signed [L-1:0] r6_wt  [3];
    logic signed [L-1:0] r6_ws  [3];
    logic signed [L-1:0] r6_wc  [3];
    logic signed [L-1:0] r6_we  [3];
    logic                r6_hb;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) r6_wax[j][i] <= r5_wax[j][i];
                r6_wt[i] <= r5_wt[i];
                r6_ws[i] <= r5_ws[i];
                r6_wc[i] <= n6_wc[i];
                r6_we[i] <= n6_we[i];
            end
            r6_hb <= r5_hb;
        end
    end

    // ---------------- output pack ----------------
    always_comb begin
        o_m_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) o_m_tdata[j*VEC_W + i*L +: L] = r6_wax[j][i];
            o_m_tdata[3*VEC_W + i*L +: L] = r6_wt[i];
            o_m_tdata[4*VEC_W + i*L +: L] = r6_ws[i];
            o_m_tdata[5*VEC_W + i*L +: L] = r6_wc[i];
            o_m_tdata[6*VEC_W + i*L +: L] = r6_we[i];
        end
    end

    assign o_m_tvalid   = r_v[NSTG];
    assign o_m_tuser[0] = r6_hb;

endmodule

/* design/cwtb_checker.sv */
// Port-level assertion checker for the transform block, with its bind.
`include "child_world_transform_and_bounds_defines.svh"

module cwtb_checker
    import cwtb_pkg::*;
#(
    parameter int LANE_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic [((9*VEC_LANES*LANE_BITS+QUAT_LANES*LANE_BITS+7)/8)*8-1:0] i_s_tdata,
    input logic [0:0] i_s_tuser,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [((OUT_FIELDS*VEC_LANES*LANE_BITS+7)/8)*8-1:0] o_m_tdata,
    input logic [0:0] o_m_tuser
);

    localparam int VEC_W = VEC_LANES * LANE_BITS;
    localparam int EXT   = 6 * VEC_W;

    // held result beat must not change
    `CWTB_ASSERT_NEXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result beat changed while stalled")

    // no bounds: centre and extents read zero
    `CWTB_ASSERT_SAME(a_nobox, o_m_tvalid && !o_m_tuser[0], o_m_tdata[OUT_FIELDS*VEC_W-1:5*VEC_W] == '0, "box fields nonzero without bounds")

    // extents are sums of magnitudes
    `CWTB_ASSERT_SAME(a_ext_pos, o_m_tvalid, !o_m_tdata[EXT+LANE_BITS-1] && !o_m_tdata[EXT+2*LANE_BITS-1] && !o_m_tdata[EXT+3*LANE_BITS-1], "negative extent lane")

    // an empty output stage means the pipe can take a beat
    `CWTB_ASSERT_SAME(a_ready, !o_m_tvalid, o_s_tready, "input stalled with empty output")

endmodule

bind child_world_transform_and_bounds cwtb_checker #(.LANE_BITS(LANE_BITS)) u_cwtb_checker (.*);

/* test/tb.sv */
// Testbench for the child world transform and bounds pipeline.
`timescale 1ns / 100ps

module tb;
    import cwtb_pkg::*;

    localparam int LB   = 16;
    localparam int PF   = LB - 8;
    localparam int RF   = LB - 2;
    localparam int IW   = ((9*VEC_LANES*LB + QUAT_LANES*LB + 7)/8)*8;
    localparam int OW   = ((OUT_FIELDS*VEC_LANES*LB + 7)/8)*8;
    localparam int NRAND    = 1450;
    localparam int DOG_MAX  = 2000;

    typedef logic signed [63:0] t_s64;

    typedef struct packed {
        logic [OW-1:0] data;
        logic          bvalid;
    } t_world;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [IW-1:0] i_s_tdata;   // position, quat w..z, lscale, pax x/y/z, ptrans, pscale, box c/e
    logic [0:0]    i_s_tuser;   // has_bounds
    logic          o_m_tvalid;
    logic          i_m_tready;
    logic [OW-1:0] o_m_tdata;   // axes x/y/z, translation, scale, box center, box extents
    logic [0:0]    o_m_tuser;   // bounds_valid

    child_world_transform_and_bounds #(.LANE_BITS(LB)) DUT (.*);

    logic [IW:0] pending_beats[$];   // {has_bounds, tdata}
    t_world      expected_world[$];
    int          errors = 0;
    int          dog = 0;
    int          results_seen = 0;
    bit          stim_done = 0;

    initial begin
        i_clk = 0;
        forever begin
            #5 i_clk = 1;
            #5 i_clk = 0;
        end
    end

    function automatic t_s64 lane(input logic [IW-1:0] w, input int idx);
        logic [LB-1:0] u;
        u = w[idx*LB +: LB];
        return $signed(u);
    endfunction

    function automatic t_s64 rnd(input t_s64 v, input int s);
        return narrow(v, s, LB);
    endfunction

    // axes ax[col][row], applied to (p*s) plus t
    function automatic void xform(input t_s64 ax[3][3], input t_s64 t[3], input t_s64 s[3],
                                  input t_s64 p[3], output t_s64 o[3]);
        t_s64 sp[3];
        t_s64 acc;
        for (int k = 0; k < 3; k++) sp[k] = rnd(p[k] * s[k], PF);
        for (int i = 0; i < 3; i++) begin
            acc = t[i] <<< RF;
            for (int k = 0; k < 3; k++) acc += ax[k][i] * sp[k];
            o[i] = rnd(acc, RF);
        end
    endfunction

    function automatic t_world compose_world(input logic [IW-1:0] d, input bit hb);
        t_s64 pos[3], lsc[3], pax[3][3], pt[3], psc[3], bc[3], be[3];
        t_s64 q[4], r[3][3], wax[3][3], wt[3], ws[3], wc[3], we[3], ex[3];
        t_s64 one, acc, a;
        t_world w;
        for (int k = 0; k < 3; k++) begin
            pos[k] = lane(d, k);
            lsc[k] = lane(d, 7 + k);
            pax[0][k] = lane(d, 10 + k);
            pax[1][k] = lane(d, 13 + k);
            pax[2][k] = lane(d, 16 + k);
            pt[k]  = lane(d, 19 + k);
            psc[k] = lane(d, 22 + k);
            bc[k]  = lane(d, 25 + k);
            be[k]  = lane(d, 28 + k);
            wc[k] = 0;
            we[k] = 0;
        end
        for (int k = 0; k < 4; k++) q[k] = lane(d, 3 + k);
        one = 64'sd1 <<< (2*RF);
        r[0][0] = rnd(one - 2*(q[2]*q[2] + q[3]*q[3]), RF);
        r[0][1] = rnd(2*(q[1]*q[2] + q[0]*q[3]), RF);
        r[0][2] = rnd(2*(q[1]*q[3] - q[0]*q[2]), RF);
        r[1][0] = rnd(2*(q[1]*q[2] - q[0]*q[3]), RF);
        r[1][1] = rnd(one - 2*(q[1]*q[1] + q[3]*q[3]), RF);
        r[1][2] = rnd(2*(q[2]*q[3] + q[0]*q[1]), RF);
        r[2][0] = rnd(2*(q[1]*q[3] + q[0]*q[2]), RF);
        r[2][1] = rnd(2*(q[2]*q[3] - q[0]*q[1]), RF);
        r[2][2] = rnd(one - 2*(q[1]*q[1] + q[2]*q[2]), RF);
        for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += pax[k][i] * r[j][k];
                wax[j][i] = rnd(acc, RF);
            end
        xform(pax, pt, psc, pos, wt);
        for (int k = 0; k < 3; k++) ws[k] = rnd(psc[k] * lsc[k], PF);
        if (hb) begin
            xform(wax, wt, ws, bc, wc);
            for (int k = 0; k < 3; k++) begin
                ex[k] = rnd(be[k] * ws[k], PF);
                if (ex[k] < 0) ex[k] = -ex[k];
            end
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) begin
                    a = wax[k][i] < 0 ? -wax[k][i] : wax[k][i];
                    acc += a * ex[k];
                end
                we[i] = rnd(acc, RF);
            end
        end
        w.data = '0;
        for (int k = 0; k < 3; k++) begin
            w.data[(0*3+k)*LB +: LB] = wax[0][k][LB-1:0];
            w.data[(1*3+k)*LB +: LB] = wax[1][k][LB-1:0];
            w.data[(2*3+k)*LB +: LB] = wax[2][k][LB-1:0];
            w.data[(3*3+k)*LB +: LB] = wt[k][LB-1:0];
            w.data[(4*3+k)*LB +: LB] = ws[k][LB-1:0];
            w.data[(5*3+k)*LB +: LB] = wc[k][LB-1:0];
            w.data[(6*3+k)*LB +: LB] = we[k][LB-1:0];
        end
        w.bvalid = hb;
        return w;
    endfunction

    // mostly short gaps, occasionally a long one, sometimes none for a while
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [LB-1:0] rlane(input int kind);
        case ($urandom_range(0, 5))
            0: return {1'b0, {(LB-1){1'b1}}};
            1: return {1'b1, {(LB-1){1'b0}}};
            2: return LB'($urandom);
            default: begin
                // moderate values that keep most stages out of saturation
                if (kind == 0) return LB'($signed($urandom_range(0, 2047)) - 1024);
                return LB'($signed($urandom_range(0, 32767)) - 16384);
            end
        endcase
    endfunction

    // kind per lane: 0 = Q8.8, 1 = Q2.14
    function automatic logic [IW:0] rand_beat(input bit unit_like);
        logic [IW:0] b;
        int ang;
        b = '0;
        for (int k = 0; k < 31; k++)
            b[k*LB +: LB] = rlane((k >= 3 && k < 7) || (k >= 10 && k < 19));
        if (unit_like) begin
            // axis-aligned quaternion and identity-like parent axes
            ang = $urandom_range(0, 3);
            for (int k = 3; k < 7; k++) b[k*LB +: LB] = '0;
            b[(3+ang)*LB +: LB] = $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
            for (int k = 10; k < 19; k++) b[k*LB +: LB] = '0;
            b[10*LB +: LB] = 16'sh4000;
            b[14*LB +: LB] = 16'sh4000;
            b[18*LB +: LB] = 16'sh4000;
        end
        b[IW] = 1'($urandom_range(0, 1));
        return b;
    endfunction

    initial begin
        logic [IW:0] b;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: identity root with and without bounds
        b = '0;
        b[3*LB +: LB] = 16'sh4000;
        for (int k = 7; k < 10; k++) b[k*LB +: LB] = 16'sh0100;
        b[10*LB +: LB] = 16'sh4000;
        b[14*LB +: LB] = 16'sh4000;
        b[18*LB +: LB] = 16'sh4000;
        for (int k = 22; k < 25; k++) b[k*LB +: LB] = 16'sh0100;
        for (int k = 25; k < 31; k++) b[k*LB +: LB] = 16'shff80;  // negative box lanes
        pending_beats.push_back(b);
        b[IW] = 1;
        pending_beats.push_back(b);
        // all-zero, all-ones, max/min lanes (non-unit quaternion saturates)
        pending_beats.push_back('0);
        pending_beats.push_back('1);
        for (int s = 0; s < 2; s++) begin
            b = '0;
            for (int k = 0; k < 31; k++)
                b[k*LB +: LB] = s ? {1'b1, {(LB-1){1'b0}}} : {1'b0, {(LB-1){1'b1}}};
            b[IW] = 1;
            pending_beats.push_back(b);
            b[IW] = 0;
            pending_beats.push_back(b);
        end
        for (int n = 0; n < 12; n++) pending_beats.push_back(rand_beat(1));
        for (int n = 0; n < NRAND; n++) pending_beats.push_back(rand_beat($urandom_range(0, 2) == 0));
        stim_done = 1;
    end

    task automatic b_drive(input logic [IW:0] beat);
        i_s_tvalid <= 1;
        i_s_tdata  <= beat[IW-1:0];
        i_s_tuser  <= beat[IW];
    endtask

    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 0;
            i_s_tdata  <= '0;
            i_s_tuser  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_world.push_back(compose_world(i_s_tdata, i_s_tuser[0]));
                src_gap = gap_len();
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 0;
                end else if (pending_beats.size() > 0) begin
                    b_drive(pending_beats.pop_front());
                end else begin
                    i_s_tvalid <= 0;
                end
            end
        end
    end

    int sink_gap = 0;
    always @(posedge i_clk) begin
        t_world w;
        if (!i_rst_n) begin
            i_m_tready <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_world.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, actual %h/%b", $time, o_m_tdata, o_m_tuser);
                end else begin
                    w = expected_world.pop_front();
                    for (int f = 0; f < OUT_FIELDS; f++)
                        if (w.data[f*3*LB +: 3*LB] !== o_m_tdata[f*3*LB +: 3*LB]) begin
                            errors++;
                            $display("%0t: field %0d expected %h actual %h", $time, f,
                                     w.data[f*3*LB +: 3*LB], o_m_tdata[f*3*LB +: 3*LB]);
                        end
                    if (w.bvalid !== o_m_tuser[0]) begin
                        errors++;
                        $display("%0t: bounds_valid expected %b actual %b", $time,
                                 w.bvalid, o_m_tuser[0]);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_tready <= 0;
            end else begin
                i_m_tready <= 1;
                if ($urandom_range(0, 3) == 0) sink_gap = gap_len();
            end
        end
    end

    // watchdog on cycles with no accepted beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) dog <= 0;
            else dog <= dog + 1;
            if (dog >= DOG_MAX) begin
                $display("watchdog expired, %0d results outstanding", expected_world.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done && i_rst_n);
        wait (pending_beats.size() == 0 && !i_s_tvalid && expected_world.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("checked %0d world transforms: identity roots, lane extremes,", results_seen);
        $display("axis-aligned and arbitrary quaternions, with and without bounds");
        if (errors == 0 && expected_world.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
